// ===== design/axis_motion_stop_detector_macros.svh =====
// Assertion macros shared by the motion stop detector checker.
`ifndef AXIS_MOTION_STOP_DETECTOR_MACROS_SVH
`define AXIS_MOTION_STOP_DETECTOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define MSD_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/msd_pkg.sv =====
// Shared types and constants of the motion stop detector.
`default_nettype none

package msd_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int DB_W    = 20;
    localparam int AXN_W   = 2;
    localparam int NUM_POS = 3;
    localparam int AXES_DEF = 3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Queue depth between front and back; must be a power of two.
    localparam int QDEPTH = 2;

    localparam logic [DB_W-1:0]   DEADBAND_RST        = DB_W'(100);
    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST    = TIME_W'(500);
    localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_RST = TIME_W'(100);
    localparam logic [AXN_W-1:0]  AXES_IN_USE_RST     = AXN_W'(3);

    typedef enum logic [1:0] {
        REG_DEADBAND,
        REG_IDLE_TIMEOUT,
        REG_SAMPLE_INTERVAL,
        REG_AXES_IN_USE
    } t_reg_idx;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic [TIME_W-1:0] idle_timeout;
        logic [TIME_W-1:0] sample_interval;
        logic [AXN_W-1:0]  axes_in_use;
    } t_cfg;

    // One group stop report: positions of the tick, busy flag, axes to report.
    typedef struct packed {
        logic [NUM_POS-1:0][POS_W-1:0] pos;
        logic                          busy;
        logic [AXN_W-1:0]              cnt;
    } t_job;

endpackage

`default_nettype wire

// ===== design/msd_queue.sv =====
// Short job queue between the tick evaluator and the report sequencer.
`default_nettype none

module msd_queue
    import msd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_cnt != CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/msd_front.sv =====
// Tick evaluator: sampling gate, per-axis movement tracking and group stop decision.
`default_nettype none

module msd_front
    import msd_pkg::*;
#(
    parameter int AXES = AXES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                 i_q_ready,
    output logic                      o_push,
    output t_job                      o_job
);

    localparam int NAX = (AXES < NUM_POS) ? AXES : NUM_POS;

    logic [TIME_W-1:0]             w_now;
    logic [NUM_POS-1:0][POS_W-1:0] w_pos;
    logic                          w_pos_valid;
    logic                          w_busy;
    logic [AXN_W-1:0]              w_n;
    logic                          w_accept;
    logic                          w_due;
    logic                          w_eval;
    logic [NAX-1:0]                w_moved;
    logic [NAX-1:0]                w_still;
    logic                          n_grp;
    logic                          w_fire;

    logic [POS_W-1:0]  r_kept [NAX];
    logic [TIME_W-1:0] r_ct   [NAX];
    logic [NAX-1:0]    r_mv;
    logic              r_grp;
    logic [TIME_W-1:0] r_last;

    assign w_now       = i_s_tdata[TIME_W-1:0];
    assign w_pos[0]    = i_s_tdata[TIME_W +: POS_W];
    assign w_pos[1]    = i_s_tdata[TIME_W + POS_W +: POS_W];
    assign w_pos[2]    = i_s_tdata[TIME_W + 2*POS_W +: POS_W];
    assign w_busy      = i_s_tdata[TIME_W + NUM_POS*POS_W];
    assign w_pos_valid = i_s_tuser[0];

    assign w_n = (i_cfg.axes_in_use > AXN_W'(NAX)) ? AXN_W'(NAX) : i_cfg.axes_in_use;

    assign o_s_tready = i_q_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_due      = (w_now - r_last) >= i_cfg.sample_interval;
    assign w_eval     = w_accept && w_due && w_pos_valid;

    for (genvar g = 0; g < NAX; g++) begin : g_lane
        logic signed [POS_W:0] diff;
        logic [POS_W:0]        mag;
        logic                  in_use;
        logic                  moved;
        logic                  mv_new;
        logic                  idle;
        logic [TIME_W-1:0]     ct_new;

        assign in_use = (AXN_W'(g) < w_n);
        assign diff   = $signed({w_pos[g][POS_W-1], w_pos[g]})
                      - $signed({r_kept[g][POS_W-1], r_kept[g]});
        assign mag    = diff[POS_W] ? $unsigned(-diff) : $unsigned(diff);
        assign moved  = in_use && (mag > (POS_W+1)'(i_cfg.deadband));
        assign ct_new = moved ? w_now : r_ct[g];
        assign mv_new = r_mv[g] || moved;
        assign idle   = (w_now - ct_new) >= i_cfg.idle_timeout;

        // Only an axis that starts moving opens a group move.
        assign w_moved[g] = moved && !r_mv[g];
        assign w_still[g] = in_use && mv_new && !idle;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_kept[g] <= '0;
                r_ct[g]   <= '0;
                r_mv[g]   <= 1'b0;
            end else if (w_eval) begin
                if (moved) begin
                    r_kept[g] <= w_pos[g];
                    r_ct[g]   <= w_now;
                end
                r_mv[g] <= mv_new && !(in_use && idle);
            end
        end
    end

    assign n_grp  = r_grp || (|w_moved);
    assign w_fire = n_grp && !(|w_still);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp  <= 1'b0;
            r_last <= '0;
        end else begin
            if (w_accept && w_due) begin
                r_last <= w_now;
            end
            if (w_eval) begin
                r_grp <= n_grp && !w_fire;
            end
        end
    end

    assign o_push    = w_eval && w_fire && (w_n != '0);
    assign o_job.pos  = w_pos;
    assign o_job.busy = w_busy;
    assign o_job.cnt  = w_n;

endmodule

`default_nettype wire

// ===== design/msd_back.sv =====
// Report sequencer: turns one queued group stop into one output item per axis.
`default_nettype none

module msd_back
    import msd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_job                 i_job,
    output logic                      o_pop,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic [M_TUSER_W-1:0]      o_m_tuser,
    output logic                      o_m_tlast
);

    t_job                 r_job;
    logic                 r_act;
    logic [AXN_W-1:0]     r_idx;
    logic                 r_ovld;
    logic [M_TDATA_W-1:0] r_tdata;
    logic [M_TUSER_W-1:0] r_tuser;
    logic                 r_tlast;
    logic                 w_slot;
    logic                 w_emit;
    logic                 w_last;

    assign w_slot = !r_ovld || i_m_tready;
    assign w_emit = r_act && w_slot;
    assign w_last = (AXN_W'(r_idx + 1'b1) == r_job.cnt);
    assign o_pop  = i_q_valid && (!r_act || (w_emit && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_slot) begin
                r_ovld <= w_emit;
            end
            if (o_pop || (w_emit && w_last)) begin
                r_idx <= '0;
            end else if (w_emit) begin
                r_idx <= AXN_W'(r_idx + 1'b1);
            end
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (w_emit && w_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_tdata <= M_TDATA_W'({r_job.busy, r_job.pos[r_idx]});
            r_tuser <= M_TUSER_W'(r_idx);
            r_tlast <= w_last;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
    assign o_m_tlast  = r_tlast;

endmodule

`default_nettype wire

// ===== design/axis_motion_stop_detector.sv =====
// Top level of the axis motion stop detector with its register port.
//
//  Channel   Direction  Signals                              Carries
//  s (in)    slave      i_s_tvalid/o_s_tready/tdata/tuser    one poll tick per item
//  m (out)   master     o_m_tvalid/i_m_tready/tdata/tuser    one axis report per item
//  apb       slave      psel/penable/pwrite/paddr/pwdata     the four control registers
//
//  A tick is evaluated in the cycle it is accepted; a tick that ends a group move
//  pushes one job into a two-entry queue, and the sequencer drains a job at one
//  output item per cycle unless the output stalls, one item per checked axis
//  (one to three). Ticks that report nothing are taken at one per cycle while the
//  queue has room; o_s_tready drops only while the queue is full. A stalled output
//  holds its item in the output register while the front keeps taking ticks.
//  Reset is synchronous and active low; registers return to their defaults.
`default_nettype none

module axis_motion_stop_detector
    import msd_pkg::*;
#(
    parameter int AXES = AXES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Register port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    // Tick input.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: now_ms[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96],
    //        job_running[128], zero fill[135:129]
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: pos_valid[0]
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    // Report output.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata: final_position[31:0], busy_res[32], zero fill[39:33]
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // tuser: axis_number[1:0]
    output logic [M_TUSER_W-1:0]      o_m_tuser,
    // tlast: last_of_group
    output logic                      o_m_tlast
);

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;
    logic     w_push;
    logic     w_q_ready;
    logic     w_q_valid;
    logic     w_pop;
    t_job     w_job_in;
    t_job     w_job_out;

    // The register port never waits. Registers sit at word addresses, so only
    // the upper address bits select one.
    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband        <= DEADBAND_RST;
            r_cfg.idle_timeout    <= IDLE_TIMEOUT_RST;
            r_cfg.sample_interval <= SAMPLE_INTERVAL_RST;
            r_cfg.axes_in_use     <= AXES_IN_USE_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_DEADBAND:        r_cfg.deadband        <= pwdata[DB_W-1:0];
                REG_IDLE_TIMEOUT:    r_cfg.idle_timeout    <= pwdata[TIME_W-1:0];
                REG_SAMPLE_INTERVAL: r_cfg.sample_interval <= pwdata[TIME_W-1:0];
                REG_AXES_IN_USE:     r_cfg.axes_in_use     <= pwdata[AXN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_DEADBAND:        prdata = PDATA_W'(r_cfg.deadband);
            REG_IDLE_TIMEOUT:    prdata = PDATA_W'(r_cfg.idle_timeout);
            REG_SAMPLE_INTERVAL: prdata = PDATA_W'(r_cfg.sample_interval);
            REG_AXES_IN_USE:     prdata = PDATA_W'(r_cfg.axes_in_use);
            default:             prdata = '0;
        endcase
    end

    // Front: applies the sampling gate, tracks each axis and decides when the
    // group has come to rest. It owns all motion state.
    msd_front #(
        .AXES (AXES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    // Queue: holds finished group stops so the front waits on the output only while the queue is full.
    msd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_job   (w_job_out),
        .i_pop   (w_pop)
    );

    // Back: walks the checked axes of one job in order, one report per cycle while the output is not stalled.
    msd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/msd_checker.sv =====
// Port-level checker for the motion stop detector and its bind.
`default_nettype none

`include "axis_motion_stop_detector_macros.svh"

module msd_checker
    import msd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 pready,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [M_TUSER_W-1:0] o_m_tuser,
    input wire logic                 o_m_tlast
);

    `MSD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled report changed")
    `MSD_ASSERT_IMPL(a_axis2_last, o_m_tvalid && (o_m_tuser == 2'd2), o_m_tlast, "third axis report is not last of group")
    `MSD_ASSERT_IMPL(a_axis_range, o_m_tvalid, o_m_tuser != 2'd3, "report names a nonexistent axis")
    `MSD_ASSERT_RST(a_reset_clean, !i_rst_n, !o_m_tvalid && o_s_tready && pready, "block not idle after reset")

endmodule

bind axis_motion_stop_detector msd_checker u_msd_checker (.*);

`default_nettype wire
